>>> rtl/fsdh_pkg.sv
// Shared constants, types and the octet-to-decimal function for the flow hash dispatcher.
// No dependencies; every other file imports this package.
package fsdh_pkg;

   localparam int CountW        = 7;
   localparam int HashW         = 32;
   localparam int CharW         = 8;
   localparam int IndexW        = 6;
   localparam int AddrW         = 32;
   localparam int PortW         = 16;
   localparam int ProtoW        = 8;
   localparam int PaddrW        = 3;
   localparam int PdataW        = 32;
   localparam int MaxWorkersDef = 64;
   localparam int ModStep       = 4;
   localparam int PortDigits    = 5;

   localparam logic [HashW-1:0]  FnvPrime   = 32'd16777619;
   localparam logic [ProtoW-1:0] ProtoTcp   = 8'd6;
   localparam logic [CharW-1:0]  CharZero   = 8'h30;
   localparam logic [CharW-1:0]  CharDot    = 8'h2e;
   localparam logic [CharW-1:0]  CharColon  = 8'h3a;
   localparam logic [15:0]       Recip10    = 16'd52429;
   localparam int                Recip10Sh  = 19;
   localparam logic [CountW-1:0] CountReset = 7'd1;
   localparam logic [0:0]        RegWorkerCount = 1'b0;

   typedef struct packed {
      logic [1:0] count;
      logic [3:0] d2;
      logic [3:0] d1;
      logic [3:0] d0;
   } oct_dec_type;

   typedef struct packed {
      logic             active;
      logic [CharW-1:0] ch;
   } key_char_type;

   function automatic oct_dec_type oct_decimal(input logic [7:0] b);
      oct_dec_type r;
      logic [7:0]  rest;
      logic [15:0] prod;
      logic [3:0]  tens;
      if (b >= 8'd200) begin
         r.d2 = 4'd2;
         rest = b - 8'd200;
      end else if (b >= 8'd100) begin
         r.d2 = 4'd1;
         rest = b - 8'd100;
      end else begin
         r.d2 = 4'd0;
         rest = b;
      end
      prod = 16'(rest) * 16'd205;
      tens = 4'(prod >> 11);
      r.d1 = tens;
      r.d0 = 4'(rest - (8'(tens) << 3) - (8'(tens) << 1));
      if (r.d2 != 4'd0) begin
         r.count = 2'd3;
      end else if (r.d1 != 4'd0) begin
         r.count = 2'd2;
      end else begin
         r.count = 2'd1;
      end
      return r;
   endfunction

endpackage

>>> rtl/fsdh_if.sv
// Valid/ready channel interfaces for packet header words and dispatch result words.
// Depends on fsdh_pkg for field widths.
interface fsdh_req_if;
   import fsdh_pkg::*;
   logic              valid;
   logic              ready;
   logic [ProtoW-1:0] protocol;
   logic [AddrW-1:0]  src_addr;
   logic [AddrW-1:0]  dst_addr;
   logic [PortW-1:0]  src_port;
   logic [PortW-1:0]  dst_port;
   modport source (output valid, protocol, src_addr, dst_addr, src_port, dst_port,
                   input ready);
   modport sink (input valid, protocol, src_addr, dst_addr, src_port, dst_port,
                 output ready);
endinterface

interface fsdh_rsp_if;
   import fsdh_pkg::*;
   logic              valid;
   logic              ready;
   logic [IndexW-1:0] worker_index;
   logic [HashW-1:0]  flow_hash;
   modport source (output valid, worker_index, flow_hash, input ready);
   modport sink (input valid, worker_index, flow_hash, output ready);
endinterface

>>> rtl/symmetric_flow_hash_dispatch.sv
// Flow: a TCP word is accepted only in idle; its result is offered after the character loop, which
// walks the longer endpoint key (9 to 21 characters) through the shared multiply-xor unit, then
// the remainder unit and the load into the result register.
// A new word is taken only once the previous TCP word's result is loaded, later while that
// result still waits; a non-TCP word is dropped with no result.
// Synchronous active-high reset: idle, no result pending, worker_count = 1.
module symmetric_flow_hash_dispatch #(
   parameter int MAX_WORKERS = fsdh_pkg::MaxWorkersDef
) (
   input  logic                         clock,
   input  logic                         reset,
   fsdh_req_if.sink                     req_bus,
   fsdh_rsp_if.source                   rsp_bus,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [fsdh_pkg::PaddrW-1:0]  csr_paddr,
   input  logic [fsdh_pkg::PdataW-1:0]  csr_pwdata,
   output logic [fsdh_pkg::PdataW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import fsdh_pkg::*;

   typedef enum logic [1:0] {
      StIdle,
      StHash,
      StMod,
      StOut
   } state_type;

   state_type         state_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic [HashW-1:0]  hash_ff;
   logic              rsp_valid_ff;
   logic [IndexW-1:0] rsp_index_ff;
   logic [HashW-1:0]  rsp_hash_ff;

   logic              csr_write;
   logic              csr_hit;
   logic [CountW-1:0] n_eff;
   logic              accept;
   logic              start_key;
   key_char_type      key0, key1;
   logic              keys_done;
   logic [CharW:0]    char_sum;
   logic [HashW-1:0]  hash_next;
   logic              mod_start;
   logic              mod_done;
   logic [CountW-1:0] mod_rem;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_hit    = (csr_paddr[PaddrW-1] == RegWorkerCount);
   assign csr_prdata = csr_hit ? PdataW'(count_ff) : '0;

   always_comb begin
      count_in = count_ff;
      if (csr_write && csr_hit) begin
         count_in = csr_pwdata[CountW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountReset;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      priority if (count_ff == '0) begin
         n_eff = CountW'(1);
      end else if ({2'b00, count_ff} > 9'(MAX_WORKERS)) begin
         n_eff = CountW'(MAX_WORKERS);
      end else begin
         n_eff = count_ff;
      end
   end

   assign req_bus.ready = (state_ff == StIdle);
   assign accept        = req_bus.valid && req_bus.ready;
   assign start_key     = accept && (req_bus.protocol == ProtoTcp);

   fsdh_keygen u_key0 (
      .clock   (clock),
      .reset   (reset),
      .start   (start_key),
      .advance (state_ff == StHash),
      .addr    (req_bus.src_addr),
      .port    (req_bus.src_port),
      .key_out (key0)
   );

   fsdh_keygen u_key1 (
      .clock   (clock),
      .reset   (reset),
      .start   (start_key),
      .advance (state_ff == StHash),
      .addr    (req_bus.dst_addr),
      .port    (req_bus.dst_port),
      .key_out (key1)
   );

   assign keys_done = !key0.active && !key1.active;
   assign char_sum  = (key0.active ? {1'b0, key0.ch} : '0)
                    + (key1.active ? {1'b0, key1.ch} : '0);
   assign hash_next = HashW'(hash_ff * FnvPrime) ^ HashW'(char_sum);
   assign mod_start = (state_ff == StHash) && keys_done;

   fsdh_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hash_ff),
      .divisor   (n_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready && (state_ff != StOut)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            StIdle: begin
               if (start_key) begin
                  hash_ff  <= '0;
                  state_ff <= StHash;
               end
            end
            StHash: begin
               if (keys_done) begin
                  state_ff <= StMod;
               end else begin
                  hash_ff <= hash_next;
               end
            end
            StMod: begin
               if (mod_done) begin
                  state_ff <= StOut;
               end
            end
            StOut: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= mod_rem[IndexW-1:0];
                  rsp_hash_ff  <= hash_ff;
                  state_ff     <= StIdle;
               end
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.worker_index = rsp_index_ff;
   assign rsp_bus.flow_hash    = rsp_hash_ff;

endmodule

>>> rtl/fsdh_keygen.sv
// Endpoint key generator: emits the "a.b.c.d:port" text one character per advance.
// Converts the port to decimal one digit a cycle; depends on fsdh_pkg.
module fsdh_keygen (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         advance,
   input  logic [fsdh_pkg::AddrW-1:0]   addr,
   input  logic [fsdh_pkg::PortW-1:0]   port,
   output fsdh_pkg::key_char_type       key_out
);
   import fsdh_pkg::*;

   localparam logic [3:0] PieceFirst = 4'd0;
   localparam logic [3:0] PieceColon = 4'd7;
   localparam logic [3:0] PiecePort  = 4'd8;
   localparam logic [3:0] PieceEnd   = 4'd9;
   localparam logic [2:0] ConvDone   = 3'(PortDigits);

   logic [3:0][7:0]            addr_ff, addr_in;
   logic [PortW-1:0]           pv_ff, pv_in;
   logic [PortDigits-1:0][3:0] pd_ff, pd_in;
   logic [2:0]                 conv_ff, conv_in;
   logic [3:0]                 piece_ff, piece_in;
   logic [2:0]                 dig_ff, dig_in;

   logic [31:0]      prod;
   logic [PortW-1:0] quot;
   logic [3:0]       new_digit;
   oct_dec_type      dec;
   logic [1:0]       opos;
   logic [3:0]       odig;
   logic [2:0]       pcount;
   logic [2:0]       ppos;
   logic [3:0]       pdig;
   logic             last;

   always_comb begin
      prod      = 32'(pv_ff) * 32'(Recip10);
      quot      = PortW'(prod >> Recip10Sh);
      new_digit = 4'(pv_ff - (quot << 3) - (quot << 1));
   end

   always_comb begin
      dec  = oct_decimal(addr_ff[~piece_ff[2:1]]);
      opos = 2'(dec.count - 2'd1 - dig_ff[1:0]);
      unique case (opos)
         2'd0:    odig = dec.d0;
         2'd1:    odig = dec.d1;
         2'd2:    odig = dec.d2;
         default: odig = 4'd0;
      endcase
   end

   always_comb begin
      priority if (pd_ff[4] != 4'd0) pcount = 3'd5;
      else if (pd_ff[3] != 4'd0)     pcount = 3'd4;
      else if (pd_ff[2] != 4'd0)     pcount = 3'd3;
      else if (pd_ff[1] != 4'd0)     pcount = 3'd2;
      else                           pcount = 3'd1;
      ppos = 3'(pcount - 3'd1 - dig_ff);
      unique case (ppos)
         3'd0:    pdig = pd_ff[0];
         3'd1:    pdig = pd_ff[1];
         3'd2:    pdig = pd_ff[2];
         3'd3:    pdig = pd_ff[3];
         3'd4:    pdig = pd_ff[4];
         default: pdig = 4'd0;
      endcase
   end

   always_comb begin
      key_out.active = 1'b1;
      priority if (piece_ff >= PieceEnd) begin
         key_out.active = 1'b0;
         key_out.ch     = '0;
         last           = 1'b0;
      end else if (piece_ff == PiecePort) begin
         key_out.ch = CharZero + CharW'(pdig);
         last       = (dig_ff == 3'(pcount - 3'd1));
      end else if (piece_ff == PieceColon) begin
         key_out.ch = CharColon;
         last       = 1'b1;
      end else if (piece_ff[0]) begin
         key_out.ch = CharDot;
         last       = 1'b1;
      end else begin
         key_out.ch = CharZero + CharW'(odig);
         last       = (dig_ff[1:0] == 2'(dec.count - 2'd1));
      end
   end

   always_comb begin
      addr_in  = addr_ff;
      pv_in    = pv_ff;
      pd_in    = pd_ff;
      conv_in  = conv_ff;
      piece_in = piece_ff;
      dig_in   = dig_ff;
      if (start) begin
         addr_in  = addr;
         pv_in    = port;
         conv_in  = '0;
         piece_in = PieceFirst;
         dig_in   = '0;
      end else begin
         if (conv_ff != ConvDone) begin
            pv_in   = quot;
            pd_in   = {new_digit, pd_ff[PortDigits-1:1]};
            conv_in = conv_ff + 3'd1;
         end
         if (advance && key_out.active) begin
            if (last) begin
               piece_in = piece_ff + 4'd1;
               dig_in   = '0;
            end else begin
               dig_in = dig_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_ff <= PieceEnd;
         dig_ff   <= '0;
         conv_ff  <= ConvDone;
      end else begin
         piece_ff <= piece_in;
         dig_ff   <= dig_in;
         conv_ff  <= conv_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      pv_ff   <= pv_in;
      pd_ff   <= pd_in;
   end

endmodule

>>> rtl/fsdh_mod.sv
// Iterative remainder unit: hash modulo worker count, ModStep quotient bits per cycle.
// Depends on fsdh_pkg for widths and the step size.
module fsdh_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fsdh_pkg::HashW-1:0]    dividend,
   input  logic [fsdh_pkg::CountW-1:0]   divisor,
   output logic                          done,
   output logic [fsdh_pkg::CountW-1:0]   remainder
);
   import fsdh_pkg::*;

   localparam int StepCount = HashW / ModStep;
   localparam int StepW     = $clog2(StepCount);

   logic [HashW-1:0]  dvd_ff, dvd_in;
   logic [CountW-1:0] rem_ff, rem_in;
   logic [CountW-1:0] dsr_ff, dsr_in;
   logic [StepW-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [CountW-1:0] r;
   logic [CountW:0]   t;

   always_comb begin
      r = rem_ff;
      for (int i = 0; i < ModStep; i++) begin
         t = {r, dvd_ff[HashW-1-i]};
         if (t >= {1'b0, dsr_ff}) begin
            t = t - {1'b0, dsr_ff};
         end
         r = t[CountW-1:0];
      end
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << ModStep;
         rem_in = r;
         cnt_in = cnt_ff + StepW'(1);
         if (cnt_ff == StepW'(StepCount - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
